[hw/rtl/yrd_pkg.sv]
// ----------------------------------------------------------------------------
// yrd_pkg
// Shared types and constants of the two-stage yaw-rate derivative block.
// ----------------------------------------------------------------------------
`default_nettype none

package yrd_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 8;

  // |rate difference| * 1000 stays below 2^42
  localparam int unsigned NumW   = 42;
  localparam int unsigned DenW   = 16;
  localparam int unsigned DivSteps = NumW / 2;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegSlopeMinGap = 8'd0;
  localparam logic [CfgIdxW-1:0] RegSlopeMaxGap = 8'd1;
  localparam logic [CfgIdxW-1:0] RegCurveMinGap = 8'd2;
  localparam logic [CfgIdxW-1:0] RegCurveMaxGap = 8'd3;

  localparam logic [CfgW-1:0] SlopeMinGapRst = 16'd40;
  localparam logic [CfgW-1:0] SlopeMaxGapRst = 16'd200;
  localparam logic [CfgW-1:0] CurveMinGapRst = 16'd290;
  localparam logic [CfgW-1:0] CurveMaxGapRst = 16'd400;

  // Stage select
  localparam logic StageSlope = 1'b0;
  localparam logic StageCurve = 1'b1;

  typedef struct packed {
    logic [CfgW-1:0] slope_min;
    logic [CfgW-1:0] slope_max;
    logic [CfgW-1:0] curve_min;
    logic [CfgW-1:0] curve_max;
  } cfg_t;

  typedef struct packed {
    logic load;      // capture input item
    logic eval;      // evaluate gap, apply non-dividing updates, start divider
    logic push;      // average quotient and push new history entry
    logic sel;       // stage select
    logic out_load;  // load result register
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_busy;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/yrd_div.sv]
// ----------------------------------------------------------------------------
// yrd_div
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module yrd_div
  import yrd_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 busy_o,
  output logic [NumW-1:0]      quo_o
);

  logic               busy_q;
  logic [DivCntW-1:0] cnt_q;
  logic [NumW-1:0]    quo_q, quo_d;
  logic [DenW-1:0]    rem_q, rem_d;
  logic [DenW-1:0]    den_q;
  logic [DenW:0]      trial;

  // Numerator bits shift out of the top of quo_q as quotient bits enter below
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    trial = '0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_d, quo_d[NumW-1]};
      if (trial >= {1'b0, den_q}) begin
        trial = trial - {1'b0, den_q};
        quo_d = {quo_d[NumW-2:0], 1'b1};
      end else begin
        quo_d = {quo_d[NumW-2:0], 1'b0};
      end
      rem_d = trial[DenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DivCntW'(DivSteps - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

[hw/rtl/yrd_datapath.sv]
// ----------------------------------------------------------------------------
// yrd_datapath
// Histories of both derivative stages, gap checks, slope divider and averaging.
// ----------------------------------------------------------------------------
`default_nettype none

module yrd_datapath
  import yrd_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cfg_t                     cfg_i,
  input  wire cmd_t                     cmd_i,
  output sts_t                          sts_o,
  input  wire logic        [DataW-1:0]  time_ms_i,
  input  wire logic signed [DataW-1:0]  turn_rate_i,
  output logic signed      [DataW-1:0]  yaw_slope_o,
  output logic signed      [DataW-1:0]  yaw_slope_rate_o
);

  // Item registers
  logic [TIME_BITS-1:0]    now_q;
  logic signed [DataW-1:0] rate_q;
  logic signed [DataW-1:0] s_q;     // stage-one derivative fed to stage two
  logic                    q_neg_q;

  // History, entry 0 newest; first index is the stage
  logic                    vld_q [2][3];
  logic [TIME_BITS-1:0]    tm_q  [2][3];
  logic signed [DataW-1:0] x_q   [2][3];
  logic signed [DataW-1:0] d_q   [2][3];

  logic signed [DataW-1:0] yaw_slope_q, yaw_slope_rate_q;

  logic                    sel;
  logic signed [DataW-1:0] val;
  logic [CfgW-1:0]         minv, maxv;
  logic [TIME_BITS-1:0]    gap;
  logic                    gap_neg, above_min, above_max, clear, v0, need_div;
  logic signed [DataW:0]   diff;
  logic signed [42:0]      diff_x, prod;
  logic [42:0]             prod_neg;
  logic [NumW-1:0]         num_mag;
  logic                    div_start, div_busy;
  logic [NumW-1:0]         quo;
  logic signed [DataW-1:0] raw;
  logic signed [DataW+1:0] sum, sum_adj, avg;
  logic signed [DataW-1:0] res;

  assign sel  = cmd_i.sel;
  assign val  = (sel == StageCurve) ? s_q : rate_q;
  assign minv = (sel == StageCurve) ? cfg_i.curve_min : cfg_i.slope_min;
  assign maxv = (sel == StageCurve) ? cfg_i.curve_max : cfg_i.slope_max;

  assign gap       = now_q - tm_q[sel][0];
  assign gap_neg   = gap[TIME_BITS-1];
  assign above_max = !gap_neg && (gap > TIME_BITS'(maxv));
  assign above_min = !gap_neg && (gap > TIME_BITS'(minv));
  assign clear     = gap_neg || above_max;
  assign v0        = vld_q[sel][0];
  assign need_div  = v0 && !clear && above_min;

  // Numerator: (val - x0) * 1000 as 1024 - 16 - 8
  assign diff     = {val[DataW-1], val} - {x_q[sel][0][DataW-1], x_q[sel][0]};
  assign diff_x   = {{(42 - DataW){diff[DataW]}}, diff};
  assign prod     = (diff_x <<< 10) - (diff_x <<< 4) - (diff_x <<< 3);
  assign prod_neg = -prod;
  assign num_mag  = prod[42] ? prod_neg[NumW-1:0] : prod[NumW-1:0];

  assign div_start = cmd_i.eval && need_div;

  // Gap is at most the 16-bit max limit whenever a division starts
  yrd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num_mag),
    .den_i  (gap[DenW-1:0]),
    .busy_o (div_busy),
    .quo_o  (quo)
  );

  // Saturate the signed quotient, then average with the stored derivatives
  always_comb begin
    if (!q_neg_q) begin
      raw = (quo > NumW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(quo[DataW-1:0]);
    end else begin
      raw = (quo > NumW'(32'h8000_0000)) ? 32'sh8000_0000
                                          : $signed(~quo[DataW-1:0] + 32'd1);
    end
    sum = {{2{d_q[sel][2][DataW-1]}}, d_q[sel][2]}
        + {{2{d_q[sel][1][DataW-1]}}, d_q[sel][1]}
        + {{2{d_q[sel][0][DataW-1]}}, d_q[sel][0]}
        + {{2{raw[DataW-1]}}, raw};
    // Round toward zero
    sum_adj = sum + (sum[DataW+1] ? 34'sd3 : 34'sd0);
    avg     = sum_adj >>> 2;
    res     = avg[DataW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= '0;
      for (int s = 0; s < 2; s++) begin
        for (int e = 0; e < 3; e++) begin
          vld_q[s][e] <= 1'b0;
          tm_q[s][e]  <= '0;
          x_q[s][e]   <= '0;
          d_q[s][e]   <= '0;
        end
      end
    end else if (cmd_i.eval) begin
      if (sel == StageSlope) begin
        s_q <= '0;
      end
      if (!v0) begin
        vld_q[sel][0] <= 1'b1;
        tm_q[sel][0]  <= now_q;
        x_q[sel][0]   <= val;
        d_q[sel][0]   <= '0;
      end else if (clear) begin
        // Drop the history; restart it with this item if the gap is long enough
        vld_q[sel][0] <= above_min;
        tm_q[sel][0]  <= above_min ? now_q : '0;
        x_q[sel][0]   <= above_min ? val : '0;
        d_q[sel][0]   <= '0;
        for (int e = 1; e < 3; e++) begin
          vld_q[sel][e] <= 1'b0;
          tm_q[sel][e]  <= '0;
          x_q[sel][e]   <= '0;
          d_q[sel][e]   <= '0;
        end
      end
    end else if (cmd_i.push) begin
      if (sel == StageSlope) begin
        s_q <= res;
      end
      for (int e = 2; e > 0; e--) begin
        vld_q[sel][e] <= vld_q[sel][e-1];
        tm_q[sel][e]  <= tm_q[sel][e-1];
        x_q[sel][e]   <= x_q[sel][e-1];
        d_q[sel][e]   <= d_q[sel][e-1];
      end
      vld_q[sel][0] <= 1'b1;
      tm_q[sel][0]  <= now_q;
      x_q[sel][0]   <= val;
      d_q[sel][0]   <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q  <= TIME_BITS'(time_ms_i);
      rate_q <= turn_rate_i;
    end
    if (div_start) begin
      q_neg_q <= prod[42];
    end
    if (cmd_i.out_load) begin
      yaw_slope_q      <= d_q[0][0];
      yaw_slope_rate_q <= d_q[1][0];
    end
  end

  assign sts_o.need_div = need_div;
  assign sts_o.div_busy = div_busy;

  assign yaw_slope_o      = yaw_slope_q;
  assign yaw_slope_rate_o = yaw_slope_rate_q;

  // A history only empties as a whole
  a_slope_hist_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[0][0] |-> (!vld_q[0][1] && !vld_q[0][2]))
    else $error("slope history has entries behind an empty head");

  a_curve_hist_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[1][0] |-> (!vld_q[1][1] && !vld_q[1][2]))
    else $error("curve history has entries behind an empty head");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire

[hw/rtl/yrd_ctrl.sv]
// ----------------------------------------------------------------------------
// yrd_ctrl
// Sequencer: capture item, run slope stage, run curve stage, hand off result.
// ----------------------------------------------------------------------------
`default_nettype none

module yrd_ctrl
  import yrd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StEval1,
    StDiv1,
    StPush1,
    StEval2,
    StDiv2,
    StPush2,
    StDone
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  always_comb begin
    cmd_o     = '0;
    cmd_o.sel = (state_q == StEval2 || state_q == StDiv2 || state_q == StPush2)
                ? StageCurve : StageSlope;
    unique case (state_q)
      StIdle:  cmd_o.load     = in_valid_i;
      StEval1: cmd_o.eval     = 1'b1;
      StPush1: cmd_o.push     = 1'b1;
      StEval2: cmd_o.eval     = 1'b1;
      StPush2: cmd_o.push     = 1'b1;
      // Hold the result until the output register is free
      StDone:  cmd_o.out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle:  if (in_valid_i) state_q <= StEval1;
        StEval1: state_q <= sts_i.need_div ? StDiv1 : StEval2;
        StDiv1:  if (!sts_i.div_busy) state_q <= StPush1;
        StPush1: state_q <= StEval2;
        StEval2: state_q <= sts_i.need_div ? StDiv2 : StDone;
        StDiv2:  if (!sts_i.div_busy) state_q <= StPush2;
        StPush2: state_q <= StDone;
        StDone:  if (cmd_o.out_load) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  a_busy_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_busy |-> (state_q == StDiv1 || state_q == StDiv2))
    else $error("divider running outside a divide state");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item taken while one is in progress");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && out_valid_q && !out_ready_i) |=> state_q == StDone)
    else $error("result left done state while output register was full");

endmodule

`default_nettype wire

[hw/rtl/yaw_rate_two_stage_derivative.sv]
// ----------------------------------------------------------------------------
// yaw_rate_two_stage_derivative
// Two-stage smoothed derivative of a filtered yaw rate (Q16.16).
//
// Input channel (in_valid_i/in_ready_o) takes a ms timestamp and a yaw rate;
// output channel (out_valid_o/out_ready_i) returns the newest smoothed slope
// and second derivative, one result per item. Config channel (cfg_valid_i,
// always ready) writes the four gap limits by index; write them while idle.
// One item is in progress at a time. From the input transfer the item runs
// the slope and curve evaluate states, plus a divide and a push state for
// each stage that divides, and its result is registered in the done state;
// each division uses one shared divider, two quotient bits per cycle.
// The input is ready again the cycle after the result is loaded, so a new item
// can start while the previous result waits. If the receiver stalls, the next
// result holds inside the block until the output register is free.
// Reset clears both histories and restores the default limits; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module yaw_rate_two_stage_derivative
  import yrd_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic        [CfgIdxW-1:0] cfg_index_i,
  input  wire logic        [CfgW-1:0]    cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic        [DataW-1:0]   time_ms_i,
  input  wire logic signed [DataW-1:0]   turn_rate_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic signed      [DataW-1:0]   yaw_slope_o,
  output logic signed      [DataW-1:0]   yaw_slope_rate_o
);

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slope_min <= SlopeMinGapRst;
      cfg_q.slope_max <= SlopeMaxGapRst;
      cfg_q.curve_min <= CurveMinGapRst;
      cfg_q.curve_max <= CurveMaxGapRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegSlopeMinGap: cfg_q.slope_min <= cfg_data_i;
        RegSlopeMaxGap: cfg_q.slope_max <= cfg_data_i;
        RegCurveMinGap: cfg_q.curve_min <= cfg_data_i;
        RegCurveMaxGap: cfg_q.curve_max <= cfg_data_i;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  yrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  yrd_datapath #(
    .TIME_BITS(TIME_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .time_ms_i       (time_ms_i),
    .turn_rate_i     (turn_rate_i),
    .yaw_slope_o     (yaw_slope_o),
    .yaw_slope_rate_o(yaw_slope_rate_o)
  );

endmodule

`default_nettype wire

[test/tb_yaw_rate_two_stage_derivative.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_yaw_rate_two_stage_derivative
// Drives timestamped yaw-rate samples through the two-stage derivative block
// and compares every result against a cycle-free model of both stages. The
// gap limits are rewritten between phases while the block is drained. Both
// channels idle at random, and the receiver holds off once so that the block
// backs up.
// ----------------------------------------------------------------------------
module tb_yaw_rate_two_stage_derivative;
  import yrd_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned TailCycles = 60;
  localparam longint SatHi = 64'sd2147483647;
  localparam longint SatLo = -64'sd2147483648;

  typedef struct packed {
    logic signed [DataW-1:0] slope;
    logic signed [DataW-1:0] curve;
  } deriv_pair_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [DataW-1:0] time_ms;
  logic signed [DataW-1:0] turn_rate;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DataW-1:0] yaw_slope;
  logic signed [DataW-1:0] yaw_slope_rate;

  // Model state, one row per stage; entry 0 is the newest
  logic hist_vld [2][3];
  logic [DataW-1:0] hist_time [2][3];
  logic signed [DataW-1:0] hist_val [2][3];
  logic signed [DataW-1:0] hist_drv [2][3];
  logic [CfgW-1:0] min_gap [2];
  logic [CfgW-1:0] max_gap [2];

  deriv_pair_t expected_derivs [$];

  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned quiet_cycles = 0;
  logic no_idle = 1'b0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int unsigned hold_left = 0;
  logic [DataW-1:0] cur_time;
  logic signed [DataW-1:0] cur_rate;

  yaw_rate_two_stage_derivative DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .time_ms_i        (time_ms),
    .turn_rate_i      (turn_rate),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .yaw_slope_o      (yaw_slope),
    .yaw_slope_rate_o (yaw_slope_rate)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic clear_stage(input logic stg);
    for (int i = 0; i < 3; i++) begin
      hist_vld[stg][i] = 1'b0;
      hist_time[stg][i] = '0;
      hist_val[stg][i] = '0;
      hist_drv[stg][i] = '0;
    end
  endtask

  // One derivative stage; drv is the derivative formed for this sample
  task automatic step_stage(input logic stg, input logic [DataW-1:0] now,
                            input logic signed [DataW-1:0] val,
                            output logic signed [DataW-1:0] drv);
    logic signed [DataW-1:0] gap32;
    logic signed [DataW-1:0] raw;
    longint gap, lim_lo, lim_hi, x_new, x_old, num, quo, sum;
    drv = '0;
    if (!hist_vld[stg][0]) begin
      hist_vld[stg][0] = 1'b1;
      hist_time[stg][0] = now;
      hist_val[stg][0] = val;
      hist_drv[stg][0] = '0;
    end else begin
      gap32 = now - hist_time[stg][0];
      gap = gap32;
      lim_lo = min_gap[stg];
      lim_hi = max_gap[stg];
      if (gap > lim_hi || gap < 0) clear_stage(stg);
      if (gap > lim_lo) begin
        if (hist_vld[stg][0]) begin
          x_new = val;
          x_old = hist_val[stg][0];
          num = (x_new - x_old) * 1000;
          quo = num / gap;
          if (quo > SatHi) raw = 32'sh7FFF_FFFF;
          else if (quo < SatLo) raw = 32'sh8000_0000;
          else raw = quo[DataW-1:0];
          sum = longint'(hist_drv[stg][2]) + longint'(hist_drv[stg][1])
              + longint'(hist_drv[stg][0]) + longint'(raw);
          sum = sum / 4;
          drv = sum[DataW-1:0];
        end
        for (int i = 2; i > 0; i--) begin
          hist_vld[stg][i] = hist_vld[stg][i-1];
          hist_time[stg][i] = hist_time[stg][i-1];
          hist_val[stg][i] = hist_val[stg][i-1];
          hist_drv[stg][i] = hist_drv[stg][i-1];
        end
        hist_vld[stg][0] = 1'b1;
        hist_time[stg][0] = now;
        hist_val[stg][0] = val;
        hist_drv[stg][0] = drv;
      end
    end
  endtask

  task automatic predict_derivs(input logic [DataW-1:0] now,
                                input logic signed [DataW-1:0] rate);
    logic signed [DataW-1:0] slope_now;
    logic signed [DataW-1:0] curve_now;
    deriv_pair_t res;
    step_stage(StageSlope, now, rate, slope_now);
    step_stage(StageCurve, now, slope_now, curve_now);
    res.slope = hist_drv[StageSlope][0];
    res.curve = hist_drv[StageCurve][0];
    expected_derivs.push_back(res);
  endtask

  // Enter at a falling edge; leave at the falling edge after the transfer
  task automatic send_sample(input logic [DataW-1:0] t, input logic signed [DataW-1:0] r);
    while (!no_idle && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    time_ms <= t;
    turn_rate <= r;
    do @(posedge clk_i); while (!in_ready);
    predict_derivs(t, r);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (expected_derivs.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      RegSlopeMinGap: min_gap[StageSlope] = val;
      RegSlopeMaxGap: max_gap[StageSlope] = val;
      RegCurveMinGap: min_gap[StageCurve] = val;
      RegCurveMaxGap: max_gap[StageCurve] = val;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_limits(input logic [CfgW-1:0] s_min, input logic [CfgW-1:0] s_max,
                            input logic [CfgW-1:0] c_min, input logic [CfgW-1:0] c_max);
    drain_results();
    write_limit(RegSlopeMinGap, s_min);
    write_limit(RegSlopeMaxGap, s_max);
    write_limit(RegCurveMinGap, c_min);
    write_limit(RegCurveMaxGap, c_max);
  endtask

  // Mostly gaps around the current limits, with some jumps and rewinds
  task automatic run_random(input int unsigned count);
    int unsigned pick;
    logic [DataW-1:0] dt;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 55) dt = $urandom_range(int'(max_gap[StageSlope]) + 30);
      else if (pick < 75) dt = $urandom_range(int'(max_gap[StageCurve]) + 60);
      else if (pick < 88) dt = $urandom_range(int'(min_gap[StageSlope]) + 1);
      else if (pick < 95) dt = $urandom;
      else dt = 32'd0 - $urandom_range(500, 1);
      cur_time = cur_time + dt;
      pick = $urandom_range(99);
      if (pick < 80) cur_rate = cur_rate + (int'($urandom_range(1 << 20)) - (1 << 19));
      else if (pick < 92) cur_rate = $urandom;
      else begin
        case ($urandom_range(3))
          0: cur_rate = 32'sh7FFF_FFFF;
          1: cur_rate = 32'sh8000_0000;
          2: cur_rate = '0;
          default: cur_rate = -32'sd1;
        endcase
      end
      send_sample(cur_time, cur_rate);
    end
  endtask

  task automatic test_directed_cases();
    send_sample(32'd1000, 32'sd0);              // empty history loads
    send_sample(32'd1010, 32'sh0001_0000);      // gap below min
    send_sample(32'd1040, 32'sh0001_0000);      // gap equal to min
    send_sample(32'd1041, 32'sh0001_0000);      // just above min
    send_sample(32'd1100, 32'sh7FFF_FFFF);
    send_sample(32'd1141, 32'sh8000_0000);      // saturate low
    send_sample(32'd1200, 32'sh7FFF_FFFF);      // saturate high
    send_sample(32'd1400, 32'sd0);              // gap equal to max
    send_sample(32'd1601, 32'sh0002_0000);      // above max: clear, restart
    send_sample(32'd1500, 32'sh0002_0000);      // rewind: clear, stay empty
    send_sample(32'd1500, -32'sd1);
    for (int k = 1; k <= 8; k++) begin
      send_sample(32'd1500 + 32'(60 * k), 32'(k * 32'sh3000) * ((k % 2) ? 1 : -1));
    end
    send_sample(32'hFFFF_FFC0, 32'sh1234);      // far behind: clear
    send_sample(32'h0000_0010, 32'sh5678);      // loads into the emptied history
    send_sample(32'h0000_0060, -32'sh5678);
    cur_time = 32'h0000_0060;
    cur_rate = -32'sh5678;
  endtask

  task automatic test_default_limits();
    run_random(80);
  endtask

  task automatic test_wide_limits();
    set_limits(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    send_sample(32'd5000, 32'sh8000_0000);
    send_sample(32'd5001, 32'sh7FFF_FFFF);      // one ms gap saturates
    send_sample(32'd5001, 32'sd0);              // zero gap holds
    send_sample(32'd5002, 32'sh8000_0000);
    send_sample(32'd70540, 32'sd1);             // beyond full-scale max
    cur_time = 32'd70540;
    run_random(80);
  endtask

  task automatic test_inverted_limits();
    set_limits(16'hFFFF, 16'd0, 16'd300, 16'd100);
    run_random(40);
    set_limits(16'd100, 16'd100, 16'd350, 16'd350);
    run_random(40);
  endtask

  task automatic test_random_limits();
    logic [CfgW-1:0] s_min, c_min;
    repeat (4) begin
      s_min = $urandom_range(120);
      c_min = $urandom_range(400);
      set_limits(s_min, s_min + 16'($urandom_range(300)), c_min,
                 c_min + 16'($urandom_range(500)));
      run_random(45);
    end
  endtask

  task automatic test_backpressure();
    set_limits(SlopeMinGapRst, SlopeMaxGapRst, CurveMinGapRst, CurveMaxGapRst);
    hold_req = ~hold_req;
    run_random(40);
  endtask

  task automatic test_steady_stream();
    no_idle = 1'b1;
    run_random(80);
    no_idle = 1'b0;
  endtask

  // Receiver: random stalls, one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk_i) begin
    deriv_pair_t exp_res;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_derivs.size() == 0) begin
        $display("%0t: result with nothing expected, slope %0d rate %0d",
                 $time, yaw_slope, yaw_slope_rate);
        error_count++;
      end else begin
        exp_res = expected_derivs.pop_front();
        results_checked++;
        if (yaw_slope !== exp_res.slope) begin
          $display("%0t: yaw_slope mismatch, expected %0d, actual %0d",
                   $time, exp_res.slope, yaw_slope);
          error_count++;
        end
        if (yaw_slope_rate !== exp_res.curve) begin
          $display("%0t: yaw_slope_rate mismatch, expected %0d, actual %0d",
                   $time, exp_res.curve, yaw_slope_rate);
          error_count++;
        end
      end
    end
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    time_ms = '0;
    turn_rate = '0;
    cur_time = '0;
    cur_rate = '0;
    clear_stage(StageSlope);
    clear_stage(StageCurve);
    min_gap[StageSlope] = SlopeMinGapRst;
    max_gap[StageSlope] = SlopeMaxGapRst;
    min_gap[StageCurve] = CurveMinGapRst;
    max_gap[StageCurve] = CurveMaxGapRst;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_default_limits();
    test_wide_limits();
    test_inverted_limits();
    test_random_limits();
    test_backpressure();
    test_steady_stream();

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (expected_derivs.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_derivs.size());
      error_count++;
    end
    $display("Checked %0d results for %0d samples across %0d limit writes.",
             results_checked, items_sent, cfg_writes);
    $display("Limits spanned zero, full scale and inverted pairs; wrap and hold-off included.");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
